[rtl/jsu_pkg.sv]
// shared types and codes for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

	// depth of the queue between parser and byte emitter
	localparam int QUEUE_DEPTH = 4;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
	localparam logic [3:0] ERR_CTRL_BYTE  = 4'd2;
	localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX    = 4'd4;
	localparam logic [3:0] ERR_NO_LOW_ESC = 4'd5;
	localparam logic [3:0] ERR_BAD_LOW    = 4'd6;
	localparam logic [3:0] ERR_LONE_LOW   = 4'd7;
	localparam logic [3:0] ERR_TEXT_END   = 4'd8;

	// one run of results: a raw byte, a code point to encode, a done or an error
	typedef struct packed {
		logic [20:0] cp;    // code point, or the raw byte in the low bits
		logic        raw;   // cp[7:0] goes out as one byte without encoding
		logic [1:0]  kind;
		logic [3:0]  err;
	} run_t;

endpackage

[rtl/jsu_front.sv]
// parser front end: takes text bytes and queues at most one run per byte
`timescale 1ns / 1ps

module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          text_end,
	output logic          push,
	output jsu_pkg::run_t push_run,
	input  logic          queue_full
);
	import jsu_pkg::*;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_STR    = 3'd1;
	localparam logic [2:0] MODE_ESC    = 3'd2;
	localparam logic [2:0] MODE_HEX1   = 3'd3;
	localparam logic [2:0] MODE_LOW_BS = 3'd4;
	localparam logic [2:0] MODE_LOW_U  = 3'd5;
	localparam logic [2:0] MODE_HEX2   = 3'd6;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [5:0] HI_SURR_TOP = 6'b110110;
	localparam logic [5:0] LO_SURR_TOP = 6'b110111;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hi_q, hi_d;
	logic        accept;
	logic        is_hex;
	logic [3:0]  hv;
	logic [15:0] acc_next;
	logic        run_valid;
	run_t        run;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// hex digit decode, either case
	always_comb begin
		is_hex = 1'b1;
		hv     = '0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hv = data_byte[3:0];
		end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
		             (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
			hv = data_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign acc_next = {acc_q[11:0], hv};

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		run_valid = 1'b0;
		run       = '{cp: '0, raw: 1'b1, kind: KIND_BYTE, err: ERR_NONE};

		unique case (mode_q)
			MODE_STR: begin
				if (text_end) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_TEXT_END;
				end else if (data_byte == CH_QUOTE) begin
					run_valid = 1'b1; run.kind = KIND_DONE;
				end else if (data_byte < CH_SPACE) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_CTRL_BYTE;
				end else if (data_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					run_valid = 1'b1; run.cp = {13'd0, data_byte};
				end
			end
			MODE_ESC: begin
				if (text_end) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_TEXT_END;
				end else if (data_byte == CH_U) begin
					mode_d = MODE_HEX1;
					cnt_d  = '0;
					acc_d  = '0;
				end else begin
					run_valid = 1'b1;
					mode_d    = MODE_STR;
					unique case (data_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: run.cp = {13'd0, data_byte};
						CH_B:    run.cp = 21'h08;
						CH_F:    run.cp = 21'h0C;
						CH_N:    run.cp = 21'h0A;
						CH_R:    run.cp = 21'h0D;
						CH_T:    run.cp = 21'h09;
						default: begin
							run.kind = KIND_ERROR; run.err = ERR_BAD_ESC;
						end
					endcase
				end
			end
			MODE_LOW_BS: begin
				if (text_end) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_TEXT_END;
				end else if (data_byte != CH_BSLASH) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_NO_LOW_ESC;
				end else begin
					mode_d = MODE_LOW_U;
				end
			end
			MODE_LOW_U: begin
				if (text_end) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_TEXT_END;
				end else if (data_byte != CH_U) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_NO_LOW_ESC;
				end else begin
					mode_d = MODE_HEX2;
					cnt_d  = '0;
					acc_d  = '0;
				end
			end
			MODE_HEX1, MODE_HEX2: begin
				if (text_end) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_TEXT_END;
				end else if (!is_hex) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_BAD_HEX;
				end else if (cnt_q != 2'd3) begin
					cnt_d = cnt_q + 2'd1;
					acc_d = acc_next;
				end else if (mode_q == MODE_HEX1) begin
					cnt_d = '0;
					acc_d = '0;
					if (acc_next[15:10] == HI_SURR_TOP) begin
						hi_d   = acc_next[9:0];
						mode_d = MODE_LOW_BS;
					end else if (acc_next[15:10] == LO_SURR_TOP) begin
						run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_LONE_LOW;
					end else begin
						run_valid = 1'b1;
						run.raw   = 1'b0;
						run.cp    = {5'd0, acc_next};
						mode_d    = MODE_STR;
					end
				end else begin
					cnt_d = '0;
					if (acc_next[15:10] != LO_SURR_TOP) begin
						run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_BAD_LOW;
					end else begin
						// supplementary plane: 0x10000 + hi[9:0] : lo[9:0]
						run_valid = 1'b1;
						run.raw   = 1'b0;
						run.cp    = 21'h10000 + {1'b0, hi_q, acc_next[9:0]};
						acc_d     = '0;
						hi_d      = '0;
						mode_d    = MODE_STR;
					end
				end
			end
			default: begin
				// idle, and the unused code treated as idle
				if (text_end || data_byte != CH_QUOTE) begin
					run_valid = 1'b1; run.kind = KIND_ERROR; run.err = ERR_NO_QUOTE;
				end else begin
					mode_d = MODE_STR;
				end
			end
		endcase

		// done and every error leave the parser in its reset state
		if (run_valid && run.kind != KIND_BYTE) begin
			mode_d = MODE_IDLE;
			cnt_d  = '0;
			acc_d  = '0;
			hi_d   = '0;
		end
	end

	assign push     = accept && run_valid;
	assign push_run = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			hi_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			hi_q   <= hi_d;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("run queued into a full queue");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_run.kind != KIND_BYTE) |=> (mode_q == MODE_IDLE && cnt_q == 2'd0))
		else $error("parser not back to idle after done or error");

	a_count_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> (mode_q == MODE_HEX1 || mode_q == MODE_HEX2))
		else $error("hex digit count left over outside a hex group");

endmodule

[rtl/jsu_fifo.sv]
// short run queue between parser and byte emitter
`timescale 1ns / 1ps

module jsu_fifo #(
	parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::run_t push_run,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output jsu_pkg::run_t head
);
	import jsu_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

	run_t          entry_q [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full   = count_q == FULL_CNT;
	assign empty  = count_q == '0;
	assign head   = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/jsu_back.sv]
// byte emitter: expands each queued run into one to four output items
`timescale 1ns / 1ps

module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  jsu_pkg::run_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [1:0]    kind,
	output logic [3:0]    err_code,
	output logic          last_of_run
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] len_m1;
	logic       fire;

	// number of utf-8 bytes minus one
	always_comb begin
		if (head.raw || head.cp[20:7] == '0) begin
			len_m1 = 2'd0;
		end else if (head.cp[20:11] == '0) begin
			len_m1 = 2'd1;
		end else if (head.cp[20:16] == '0) begin
			len_m1 = 2'd2;
		end else begin
			len_m1 = 2'd3;
		end
	end

	always_comb begin
		out_byte = head.cp[7:0];
		unique case (len_m1)
			2'd1: begin
				unique case (idx_q)
					2'd0:    out_byte = {3'b110, head.cp[10:6]};
					default: out_byte = {2'b10, head.cp[5:0]};
				endcase
			end
			2'd2: begin
				unique case (idx_q)
					2'd0:    out_byte = {4'b1110, head.cp[15:12]};
					2'd1:    out_byte = {2'b10, head.cp[11:6]};
					default: out_byte = {2'b10, head.cp[5:0]};
				endcase
			end
			2'd3: begin
				unique case (idx_q)
					2'd0: out_byte = {5'b11110, head.cp[20:18]};
					2'd1: out_byte = {2'b10, head.cp[17:12]};
					2'd2: out_byte = {2'b10, head.cp[11:6]};
					2'd3: out_byte = {2'b10, head.cp[5:0]};
				endcase
			end
			default: out_byte = head.cp[7:0];
		endcase
	end

	assign out_valid   = !empty;
	assign kind        = head.kind;
	assign err_code    = head.err;
	assign last_of_run = idx_q == len_m1;
	assign fire        = out_valid && out_ready;
	assign pop         = fire && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_multi_only_encoded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && idx_q != 2'd0) |-> (kind == KIND_BYTE && !head.raw))
		else $error("continuation item on a single-item run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !last_of_run) |=> (out_valid && idx_q != 2'd0))
		else $error("run dropped before its last item");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_BYTE) |-> (last_of_run && out_byte == 8'd0))
		else $error("done or error item not a lone zero-byte item");

endmodule

[rtl/json_string_unescape_utf8.sv]
// top level of the json string unescaper with utf-8 output
`timescale 1ns / 1ps

//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: text_end
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_byte, err_code;
//                                               tuser: kind; tlast: last_of_run
//
//  one input item per cycle while the run queue has room; the parser decides combinationally in the accepting cycle
//  each input gives zero to four output items, one per cycle, set by the output port
//  the queue holds QueueDepth runs; input stalls only while all of them wait
//  arst_n clears parser state, queue pointers and the byte index; no clearing pass
//  first output item of a run appears once the run is registered in the queue and the runs ahead of it are out

module json_string_unescape_utf8 #(
	parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] text_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] err_code, rest zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last item caused by one input item
);
	import jsu_pkg::*;

	// front to queue
	logic       push;
	run_t       push_run;
	logic       queue_full;
	// queue to back
	logic       pop;
	logic       queue_empty;
	run_t       head;
	// decoded result fields
	logic [7:0] out_byte;
	logic [3:0] err_code;

	// parser: mode machine, hex gathering and surrogate pairing
	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.text_end   (s_axis_tuser),
		.push       (push),
		.push_run   (push_run),
		.queue_full (queue_full)
	);

	// run queue decoupling parser from output stalls
	jsu_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head     (head)
	);

	// utf-8 encoder and item sequencer
	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (queue_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (out_byte),
		.kind        (m_axis_tuser),
		.err_code    (err_code),
		.last_of_run (m_axis_tlast)
	);

	// pack fields, first field lowest, zero padded to two bytes
	assign m_axis_tdata = {4'd0, err_code, out_byte};

endmodule

[tb/sv/testbench.sv]
// testbench for the json string unescaper: directed and random strings, predicted and checked
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_U      = "u";
	localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
	localparam logic [15:0] BMP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
	localparam int NO_BAD_DIGIT = 4;
	localparam int RANDOM_ITEMS = 460;
	localparam int REPORT_LIMIT = 10;
	localparam int END_WAIT     = 16;

	typedef enum logic [2:0] {
		P_IDLE, P_STR, P_ESC, P_HEX1, P_LOW_BS, P_LOW_U, P_HEX2
	} parse_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] err;
		logic       last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;    // [0] text_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [7:0] out_byte, [11:8] err_code
	logic [1:0]  m_axis_tuser;           // [1:0] kind
	logic        m_axis_tlast;

	// decoder model state
	parse_state_t parse_state;
	logic [1:0]   hex_count;
	logic [15:0]  hex_acc;
	logic [15:0]  high_half;
	result_t      decoded_q[$];
	result_t      want;

	int   n_sent = 0;
	int   n_fail = 0;
	int   n_bytes = 0;
	int   n_closed = 0;
	int   n_errors = 0;
	logic [15:0] err_seen = '0;
	int   burst_left = 0;
	bit   full_speed = 1'b0;
	bit   rx_open = 1'b0;
	int   rx_run = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	json_string_unescape_utf8 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// ---------------------------------------------------------------- prediction

	function automatic void reset_parser();
		parse_state = P_IDLE;
		hex_count = '0;
		hex_acc = '0;
		high_half = '0;
	endfunction

	function automatic void push_result(input logic [7:0] b, input logic [1:0] k,
			input logic [3:0] e);
		result_t r;
		r = '{out_byte: b, kind: k, err: e, last: 1'b0};
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	function automatic void decode_error(input logic [3:0] code);
		reset_parser();
		push_result(8'h00, KIND_ERROR, code);
	endfunction

	// bit 4 set when the byte is no hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic void push_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_result(cp[7:0], KIND_BYTE, ERR_NONE);
		end else if (cp <= 21'h7FF) begin
			push_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
		end else if (cp <= 21'hFFFF) begin
			push_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
		end else begin
			push_result({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
			push_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
		end
	endfunction

	function automatic void predict_item(input logic [7:0] c, input logic fin);
		int          n0;
		logic [4:0]  nib;
		logic [15:0] grp;
		logic [20:0] cp;
		n0 = decoded_q.size();
		if (parse_state == P_IDLE) begin
			if (fin || c != CH_QUOTE) decode_error(ERR_NO_QUOTE);
			else parse_state = P_STR;
		end else if (fin) begin
			decode_error(ERR_TEXT_END);
		end else begin
			case (parse_state)
				P_STR: begin
					if (c == CH_QUOTE) begin
						reset_parser();
						push_result(8'h00, KIND_DONE, ERR_NONE);
					end else if (c < CH_SPACE) begin
						decode_error(ERR_CTRL_BYTE);
					end else if (c == CH_BSLASH) begin
						parse_state = P_ESC;
					end else begin
						push_result(c, KIND_BYTE, ERR_NONE);
					end
				end
				P_ESC: begin
					parse_state = P_STR;
					case (c)
						CH_QUOTE, CH_BSLASH, "/": push_result(c, KIND_BYTE, ERR_NONE);
						"b": push_result(8'h08, KIND_BYTE, ERR_NONE);
						"f": push_result(8'h0C, KIND_BYTE, ERR_NONE);
						"n": push_result(8'h0A, KIND_BYTE, ERR_NONE);
						"r": push_result(8'h0D, KIND_BYTE, ERR_NONE);
						"t": push_result(8'h09, KIND_BYTE, ERR_NONE);
						CH_U: begin
							parse_state = P_HEX1;
							hex_count = '0;
							hex_acc = '0;
						end
						default: decode_error(ERR_BAD_ESC);
					endcase
				end
				P_LOW_BS: begin
					if (c != CH_BSLASH) decode_error(ERR_NO_LOW_ESC);
					else parse_state = P_LOW_U;
				end
				P_LOW_U: begin
					if (c != CH_U) begin
						decode_error(ERR_NO_LOW_ESC);
					end else begin
						parse_state = P_HEX2;
						hex_count = '0;
						hex_acc = '0;
					end
				end
				default: begin
					// hex digit of the first or the second group
					nib = hex_nibble(c);
					if (nib[4]) begin
						decode_error(ERR_BAD_HEX);
					end else begin
						hex_acc = {hex_acc[11:0], nib[3:0]};
						if (hex_count != 2'd3) begin
							hex_count = hex_count + 2'd1;
						end else begin
							hex_count = '0;
							grp = hex_acc;
							hex_acc = '0;
							if (parse_state == P_HEX1) begin
								if (grp >= 16'hD800 && grp <= 16'hDBFF) begin
									high_half = grp;
									parse_state = P_LOW_BS;
								end else if (grp >= 16'hDC00 && grp <= 16'hDFFF) begin
									decode_error(ERR_LONE_LOW);
								end else begin
									parse_state = P_STR;
									push_utf8({5'd0, grp});
								end
							end else if (grp < 16'hDC00 || grp > 16'hDFFF) begin
								decode_error(ERR_BAD_LOW);
							end else begin
								// high half carries bits 19:10, low half bits 9:0
								cp = 21'h10000 + {1'b0, high_half[9:0], grp[9:0]};
								high_half = '0;
								parse_state = P_STR;
								push_utf8(cp);
							end
						end
					end
				end
			endcase
		end
		if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void note_failure(input string msg);
		n_fail++;
		if (n_fail <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				note_failure($sformatf("item with none expected: tdata %h kind %0d last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = decoded_q.pop_front();
				case (want.kind)
					KIND_BYTE: n_bytes++;
					KIND_DONE: n_closed++;
					default: n_errors++;
				endcase
				err_seen[want.err] = 1'b1;
				if (m_axis_tdata !== {4'h0, want.err, want.out_byte} || m_axis_tuser !== want.kind
						|| m_axis_tlast !== want.last)
					note_failure($sformatf(
						"expected byte %h kind %0d error %0d last %0b, got tdata %h kind %0d last %0b",
						want.out_byte, want.kind, want.err, want.last,
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end
		end
	end

	// output side: alternating runs of ready and stall, or always ready at full speed
	always @(negedge clk) begin
		if (full_speed) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_run <= 0) begin
				rx_open = !rx_open;
				rx_run = rx_open ? $urandom_range(1, 16) : $urandom_range(1, 6);
			end
			rx_run--;
			m_axis_tready <= rx_open;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// one item, sent in bursts with random gaps unless at full speed; the model runs on acceptance
	task automatic send_item(input logic [7:0] b, input logic fin);
		int gap;
		@(negedge clk);
		if (!full_speed && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_sent++;
		predict_item(b, fin);
	endtask

	// hold the input off until every predicted item has come out
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic upper;
		upper = 1'($urandom_range(0, 1));
		if (n < 4'd10) return "0" + n;
		return (upper ? "A" : "a") + (n - 4'd10);
	endfunction

	// four hex digits; the digit at bad_pos is replaced by a non-hex byte and the group stops
	task automatic send_hex4(input logic [15:0] v, input int bad_pos);
		int         i;
		logic [7:0] c;
		logic [4:0] nib;
		for (i = 0; i < 4; i++) begin
			if (i == bad_pos) begin
				do begin
					c = 8'($urandom_range(0, 255));
					nib = hex_nibble(c);
				end while (!nib[4]);
				send_item(c, 1'b0);
				return;
			end
			send_item(hex_char(v[15 - 4 * i -: 4]), 1'b0);
		end
	endtask

	task automatic send_u(input logic [15:0] v, input int bad_pos);
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		send_hex4(v, bad_pos);
	endtask

	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [15:0] rand_bmp();
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: v = 16'($urandom_range(0, 16'h7F));
			1: v = 16'($urandom_range(16'h80, 16'h7FF));
			2: v = 16'($urandom_range(16'h800, 16'hD7FF));
			3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
			4: v = BMP_EDGES[3'($urandom_range(0, 7))];
			default: do v = 16'($urandom_range(0, 16'hFFFF));
				while (v inside {[16'hD800:16'hDFFF]});
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rand_high();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
		return 16'($urandom_range(16'hD800, 16'hDBFF));
	endfunction

	function automatic logic [15:0] rand_low();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
		return 16'($urandom_range(16'hDC00, 16'hDFFF));
	endfunction

	task automatic send_good_token();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: send_item(rand_plain(), 1'b0);
			4, 5: begin
				send_item(CH_BSLASH, 1'b0);
				send_item(ESC_LETTERS[3'($urandom_range(0, 7))], 1'b0);
			end
			6, 7: send_u(rand_bmp(), NO_BAD_DIGIT);
			default: begin
				send_u(rand_high(), NO_BAD_DIGIT);
				send_u(rand_low(), NO_BAD_DIGIT);
			end
		endcase
	endtask

	// a fragment that ends the string with an error
	task automatic send_broken_token();
		int          k;
		logic [7:0]  c;
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: send_item(8'($urandom_range(0, 8'h1F)), 1'b0);
			1: begin
				send_item(CH_BSLASH, 1'b0);
				do c = 8'($urandom_range(0, 255));
				while (c inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", CH_U});
				send_item(c, 1'b0);
			end
			2: send_u(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
			3: begin
				send_u(rand_high(), NO_BAD_DIGIT);
				send_u(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
			end
			4: begin
				// high half not followed by a backslash and u
				send_u(rand_high(), NO_BAD_DIGIT);
				if ($urandom_range(0, 1)) begin
					do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
				end else begin
					send_item(CH_BSLASH, 1'b0);
					do c = 8'($urandom_range(0, 255)); while (c == CH_U);
				end
				send_item(c, 1'b0);
			end
			5: begin
				send_u(rand_high(), NO_BAD_DIGIT);
				do v = 16'($urandom_range(0, 16'hFFFF)); while (v inside {[16'hDC00:16'hDFFF]});
				send_u(v, NO_BAD_DIGIT);
			end
			6: send_u(rand_low(), NO_BAD_DIGIT);
			default: begin
				// end of text, possibly in the middle of an escape or a pair
				case ($urandom_range(0, 3))
					1: send_item(CH_BSLASH, 1'b0);
					2: begin
						send_item(CH_BSLASH, 1'b0);
						send_item(CH_U, 1'b0);
						for (k = $urandom_range(0, 3); k > 0; k--)
							send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
					end
					3: begin
						send_u(rand_high(), NO_BAD_DIGIT);
						if ($urandom_range(0, 1)) send_item(CH_BSLASH, 1'b0);
					end
					default: ;
				endcase
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	task automatic send_random_string();
		int n_tok;
		int err_at;
		int i;
		full_speed = ($urandom_range(0, 7) == 0);
		n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
		err_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_tok) : -1;
		send_item(CH_QUOTE, 1'b0);
		for (i = 0; i < n_tok; i++) begin
			if (i == err_at) begin
				send_broken_token();
				return;
			end
			send_good_token();
		end
		if (err_at == n_tok) send_broken_token();
		else send_item(CH_QUOTE, 1'b0);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_idle_errors();
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);
	endtask

	task automatic test_plain_and_escape();
		send_text("\"\\t");
		send_item(8'hFF, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_QUOTE, 1'b0);
	endtask

	task automatic test_control_byte();
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h1F, 1'b0);
	endtask

	task automatic test_surrogate_pair();
		send_text("\"\\uD83d\\uDE00\"");
	endtask

	task automatic test_text_end();
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	task automatic test_random_strings();
		int         stop_at;
		logic [7:0] c;
		stop_at = n_sent + RANDOM_ITEMS;
		while (n_sent < stop_at) begin
			send_random_string();
			if ($urandom_range(0, 9) == 0) begin
				// stray input between strings
				do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
				send_item(c, $urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
		full_speed = 1'b0;
	endtask

	initial begin
		reset_parser();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_errors();
		wait_drained();
		test_plain_and_escape();
		wait_drained();
		test_control_byte();
		test_surrogate_pair();
		wait_drained();
		test_text_end();
		wait_drained();
		test_random_strings();
		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		$display("sent %0d input items; got %0d bytes, %0d closed strings, %0d errors",
			n_sent, n_bytes, n_closed, n_errors);
		$display("error codes reached (one bit per code): %b, mismatches: %0d",
			err_seen[8:0], n_fail);
		if (n_fail == 0) begin
			$display("json_string_unescape_utf8 test passed");
		end else begin
			$display("json_string_unescape_utf8 test failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d items still expected", decoded_q.size());
		$display("json_string_unescape_utf8 test failed");
		$finish;
	end

endmodule
